### sv/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// shared types and constants of the distance-vector route table
// ----------------------------------------------------------------------------
`default_nettype none

package dvrt_pkg;

    localparam logic [9:0]  UNREACHABLE   = 10'd999;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10;

    // configuration register index, taken from paddr[2]
    localparam logic REG_OWN_ADDRESS      = 1'b0;
    localparam logic REG_NEIGHBOR_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        KIND_HELLO  = 3'd0,
        KIND_VECTOR = 3'd1,
        KIND_TICK   = 3'd2,
        KIND_SENT   = 3'd3,
        KIND_QUERY  = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_NBR_SCAN, S_NBR_DEC, S_LOOK_RD, S_LOOK_CHK,
        S_VIA_RD, S_VIA_CHK, S_APPLY, S_DONE, S_TICK, S_DROP_RD,
        S_DROP_CHK, S_DV_RD, S_DV_CHK, S_DV_END
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_IDLE, OP_NBR_SCAN, OP_NBR_DEC, OP_LOOK_RD,
        OP_LOOK_CHK, OP_VIA_RD, OP_VIA_CHK, OP_APPLY, OP_DONE, OP_TICK_CHK,
        OP_DROP_RD, OP_DROP_CHK, OP_DV_RD, OP_DV_CHK, OP_DV_END
    } t_dp_op;

    typedef struct packed {
        logic       in_valid;
        logic [2:0] kind;
        logic       own_sender;
        logic       clear_last;
        logic       nbr_last;
        logic       look_hit;
        logic       dest_last;
        logic       via_last;
        logic       tick_drop;
        logic       tick_last;
        logic       dcnt_zero;
        logic       dv_last;
        logic       out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### sv/dvrt_if.sv
// ----------------------------------------------------------------------------
// dvrt_in_if / dvrt_out_if
// valid/ready channels of the route table
// ----------------------------------------------------------------------------
`default_nettype none

interface dvrt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] sender_address;
    logic [31:0] destination_address;
    logic [15:0] sequence_req;
    logic [9:0]  advertised_distance;

    modport source (output valid, kind, sender_address, destination_address,
                    sequence_req, advertised_distance, input ready);
    modport sink   (input valid, kind, sender_address, destination_address,
                    sequence_req, advertised_distance, output ready);
endinterface

interface dvrt_out_if;
    logic       valid;
    logic       ready;
    logic       best_changed;
    logic [9:0] best_distance;
    logic       update_pending;
    logic       table_full;
    logic [3:0] neighbors_lost;

    modport source (output valid, best_changed, best_distance, update_pending,
                    table_full, neighbors_lost, input ready);
    modport sink   (input valid, best_changed, best_distance, update_pending,
                    table_full, neighbors_lost, output ready);
endinterface

`default_nettype wire

### sv/dvrt_ram.sv
// ----------------------------------------------------------------------------
// dvrt_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/dvrt_ctrl.sv
// ----------------------------------------------------------------------------
// dvrt_ctrl
// sequencer of the route table: except while S_DONE waits on the output, one datapath operation per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_ctrl
    import dvrt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_status i_status,
    output t_dp_op          o_op
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_op = OP_IDLE;
                if (i_status.in_valid) begin
                    if (i_status.kind == KIND_HELLO) begin
                        n_state = i_status.own_sender ? S_LOOK_RD : S_NBR_SCAN;
                    end else if (i_status.kind == KIND_TICK) begin
                        n_state = S_TICK;
                    end else begin
                        n_state = S_LOOK_RD;
                    end
                end
            end
            S_NBR_SCAN: begin
                o_op = OP_NBR_SCAN;
                if (i_status.nbr_last) n_state = S_NBR_DEC;
            end
            S_NBR_DEC: begin
                o_op    = OP_NBR_DEC;
                n_state = S_LOOK_RD;
            end
            S_LOOK_RD: begin
                o_op    = OP_LOOK_RD;
                n_state = S_LOOK_CHK;
            end
            S_LOOK_CHK: begin
                o_op = OP_LOOK_CHK;
                if (i_status.look_hit)       n_state = S_VIA_RD;
                else if (i_status.dest_last) n_state = S_APPLY;
                else                         n_state = S_LOOK_RD;
            end
            S_VIA_RD: begin
                o_op    = OP_VIA_RD;
                n_state = i_status.via_last ? S_APPLY : S_VIA_CHK;
            end
            S_VIA_CHK: begin
                o_op    = OP_VIA_CHK;
                n_state = S_VIA_RD;
            end
            S_APPLY: begin
                o_op    = OP_APPLY;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_op    = OP_DONE;
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                o_op = OP_TICK_CHK;
                if (i_status.tick_drop)      n_state = S_DROP_RD;
                else if (i_status.tick_last) n_state = S_LOOK_RD;
            end
            S_DROP_RD: begin
                o_op    = OP_DROP_RD;
                n_state = S_DROP_CHK;
            end
            S_DROP_CHK: begin
                o_op = OP_DROP_CHK;
                if (!i_status.dcnt_zero)     n_state = S_DV_RD;
                else if (i_status.dest_last) n_state = S_TICK;
                else                         n_state = S_DROP_RD;
            end
            S_DV_RD: begin
                o_op    = OP_DV_RD;
                n_state = i_status.dv_last ? S_DV_END : S_DV_CHK;
            end
            S_DV_CHK: begin
                o_op    = OP_DV_CHK;
                n_state = S_DV_RD;
            end
            S_DV_END: begin
                o_op    = OP_DV_END;
                n_state = i_status.dest_last ? S_TICK : S_DROP_RD;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/dvrt_dp.sv
// ----------------------------------------------------------------------------
// dvrt_dp
// route table datapath: neighbour table, destination and via memories
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_dp
    import dvrt_pkg::*;
#(
    parameter int NEIGHBOR_SLOTS = 8,
    parameter int DEST_SLOTS     = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_op      i_op,
    output t_dp_status       o_status,
    input  wire logic [31:0] i_own_address,
    input  wire logic [15:0] i_timeout_secs,
    dvrt_in_if.sink          i_item,
    dvrt_out_if.source       o_result
);

    localparam int NW    = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
    localparam int NCW   = $clog2(NEIGHBOR_SLOTS + 1);
    localparam int DW    = (DEST_SLOTS > 1) ? $clog2(DEST_SLOTS) : 1;
    localparam int VAW   = DW + NW;
    localparam int VDEP  = DEST_SLOTS * (2 ** NW);
    localparam int DWID  = 32 + NCW;
    localparam int VWID  = 42;

    function automatic logic [9:0] min_dist(input logic [9:0] a, input logic [9:0] b);
        return (b < a) ? b : a;
    endfunction

    // item registers
    logic [2:0]  r_kind;
    logic [31:0] r_sender;
    logic [31:0] r_target;
    logic [15:0] r_seq;
    logic [9:0]  r_cost;
    logic        r_do_set;
    logic        r_changed;
    logic        r_full;
    logic [3:0]  r_lost;
    logic        r_pending;
    logic [31:0] r_seconds;
    logic [9:0]  r_best;

    // neighbour table
    logic        r_nv [NEIGHBOR_SLOTS];
    logic [31:0] r_na [NEIGHBOR_SLOTS];
    logic [15:0] r_ns [NEIGHBOR_SLOTS];
    logic [31:0] r_nh [NEIGHBOR_SLOTS];
    logic [NW-1:0] r_ni, r_nhit_idx, r_nfree_idx;
    logic          r_nhit, r_newer, r_nfree;

    // destination scan
    logic [DW-1:0]  r_k, r_d, r_dfree_idx;
    logic           r_found, r_dfree, r_match;
    logic [NCW-1:0] r_dcnt, r_j, r_w;
    logic [NW-1:0]  r_mj;
    logic [31:0]    r_daddr, r_drop_addr;
    logic [9:0]     r_min_all, r_min_oth, r_dmin_old, r_dmin_new;

    // result register
    logic       r_ov, r_ochg, r_opend, r_ofull;
    logic [9:0] r_obest;
    logic [3:0] r_olost;

    // memories
    logic            dest_we, via_we;
    logic [DW-1:0]   dest_waddr;
    logic [VAW-1:0]  via_waddr, via_raddr;
    logic [DWID-1:0] dest_wdata, dest_rdata;
    logic [VWID-1:0] via_wdata, via_rdata;

    logic [NCW-1:0] dest_rd_cnt;
    logic [31:0]    dest_rd_addr, via_rd_addr, silence;
    logic [9:0]     via_rd_dist, old_best, new_best;
    logic           apply_full, accept, via_keep;
    logic [10:0]    adv_sum;

    dvrt_ram #(.WIDTH(DWID), .DEPTH(DEST_SLOTS)) u_dest_ram (
        .i_clk  (i_clk),
        .i_we   (dest_we),
        .i_waddr(dest_waddr),
        .i_wdata(dest_wdata),
        .i_raddr(r_k),
        .o_rdata(dest_rdata)
    );

    dvrt_ram #(.WIDTH(VWID), .DEPTH(VDEP)) u_via_ram (
        .i_clk  (i_clk),
        .i_we   (via_we),
        .i_waddr(via_waddr),
        .i_wdata(via_wdata),
        .i_raddr(via_raddr),
        .o_rdata(via_rdata)
    );

    assign dest_rd_cnt  = dest_rdata[NCW-1:0];
    assign dest_rd_addr = dest_rdata[DWID-1:NCW];
    assign via_rd_dist  = via_rdata[9:0];
    assign via_rd_addr  = via_rdata[VWID-1:10];
    assign via_keep     = (via_rd_addr != r_drop_addr);
    assign via_raddr    = (i_op == OP_DV_RD) ? {r_k, r_j[NW-1:0]} : {r_d, r_j[NW-1:0]};
    assign silence      = r_seconds - r_nh[r_ni];
    assign adv_sum      = {1'b0, i_item.advertised_distance} + 11'd1;

    assign i_item.ready = (i_op == OP_IDLE);
    assign accept       = i_item.ready && i_item.valid;

    always_comb begin
        o_status.in_valid   = i_item.valid;
        o_status.kind       = i_item.kind;
        o_status.own_sender = (i_item.sender_address == i_own_address);
        o_status.clear_last = (r_k == DW'(DEST_SLOTS - 1));
        o_status.dest_last  = (r_k == DW'(DEST_SLOTS - 1));
        o_status.nbr_last   = (r_ni == NW'(NEIGHBOR_SLOTS - 1));
        o_status.tick_last  = (r_ni == NW'(NEIGHBOR_SLOTS - 1));
        o_status.look_hit   = (dest_rd_cnt != '0) && (dest_rd_addr == r_target);
        o_status.via_last   = (r_j == r_dcnt);
        o_status.dv_last    = (r_j == r_dcnt);
        o_status.tick_drop  = r_nv[r_ni] && (silence > {16'd0, i_timeout_secs});
        o_status.dcnt_zero  = (dest_rd_cnt == '0);
        o_status.out_free   = !r_ov || o_result.ready;
    end

    // cost update decision at the end of a lookup
    always_comb begin
        old_best   = r_found ? r_min_all : UNREACHABLE;
        new_best   = old_best;
        apply_full = 1'b0;
        if (!r_found) begin
            if (r_dfree) new_best = r_cost;
            else         apply_full = 1'b1;
        end else if (r_match) begin
            new_best = min_dist(r_min_oth, r_cost);
        end else if (r_dcnt < NCW'(NEIGHBOR_SLOTS)) begin
            new_best = min_dist(r_min_all, r_cost);
        end else begin
            apply_full = 1'b1;
        end
    end

    // memory write selection
    always_comb begin
        dest_we    = 1'b0;
        dest_waddr = r_k;
        dest_wdata = '0;
        via_we     = 1'b0;
        via_waddr  = {r_d, r_mj};
        via_wdata  = {r_sender, r_cost};
        priority case (i_op)
            OP_CLEAR: begin
                dest_we = 1'b1;
            end
            OP_APPLY: begin
                if (r_do_set) begin
                    if (!r_found) begin
                        if (r_dfree) begin
                            dest_we    = 1'b1;
                            dest_waddr = r_dfree_idx;
                            dest_wdata = {r_target, NCW'(1)};
                            via_we     = 1'b1;
                            via_waddr  = {r_dfree_idx, NW'(0)};
                        end
                    end else if (r_match) begin
                        via_we = 1'b1;
                    end else if (r_dcnt < NCW'(NEIGHBOR_SLOTS)) begin
                        via_we     = 1'b1;
                        via_waddr  = {r_d, r_dcnt[NW-1:0]};
                        dest_we    = 1'b1;
                        dest_waddr = r_d;
                        dest_wdata = {r_target, r_dcnt + NCW'(1)};
                    end
                end
            end
            OP_DV_CHK: begin
                via_we    = via_keep;
                via_waddr = {r_k, r_w[NW-1:0]};
                via_wdata = via_rdata;
            end
            OP_DV_END: begin
                dest_we    = 1'b1;
                dest_wdata = {r_daddr, r_w};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_ov      <= 1'b0;
            r_pending <= 1'b0;
            r_seconds <= '0;
            for (int i = 0; i < NEIGHBOR_SLOTS; i++) r_nv[i] <= 1'b0;
        end else begin
            if (r_ov && o_result.ready && (i_op != OP_DONE)) r_ov <= 1'b0;
            unique case (i_op)
                OP_CLEAR: begin
                    r_k <= r_k + DW'(1);
                end
                OP_IDLE: begin
                    if (accept) begin
                        r_kind    <= i_item.kind;
                        r_sender  <= i_item.sender_address;
                        r_target  <= (i_item.kind == KIND_HELLO) ? i_item.sender_address
                                                                 : i_item.destination_address;
                        r_seq     <= i_item.sequence_req;
                        r_cost    <= (adv_sum > 11'd999) ? UNREACHABLE : adv_sum[9:0];
                        r_do_set  <= (i_item.kind == KIND_VECTOR) &&
                                     (i_item.sender_address != i_own_address);
                        r_changed <= 1'b0;
                        r_full    <= 1'b0;
                        r_lost    <= '0;
                        r_ni      <= '0;
                        r_nhit    <= 1'b0;
                        r_nfree   <= 1'b0;
                        r_newer   <= 1'b0;
                        r_k       <= '0;
                        r_found   <= 1'b0;
                        r_dfree   <= 1'b0;
                        r_match   <= 1'b0;
                        r_min_all <= UNREACHABLE;
                        r_min_oth <= UNREACHABLE;
                        if (i_item.kind == KIND_TICK) r_seconds <= r_seconds + 32'd1;
                        if (i_item.kind == KIND_SENT) r_pending <= 1'b0;
                    end
                end
                OP_NBR_SCAN: begin
                    if (r_nv[r_ni] && (r_na[r_ni] == r_sender) && !r_nhit) begin
                        r_nhit     <= 1'b1;
                        r_nhit_idx <= r_ni;
                        r_newer    <= (r_seq > r_ns[r_ni]);
                    end
                    if (!r_nv[r_ni] && !r_nfree) begin
                        r_nfree     <= 1'b1;
                        r_nfree_idx <= r_ni;
                    end
                    r_ni <= r_ni + NW'(1);
                end
                OP_NBR_DEC: begin
                    if (r_nhit) begin
                        if (r_newer) begin
                            r_ns[r_nhit_idx] <= r_seq;
                            r_nh[r_nhit_idx] <= r_seconds;
                        end
                    end else if (r_nfree) begin
                        r_nv[r_nfree_idx] <= 1'b1;
                        r_na[r_nfree_idx] <= r_sender;
                        r_ns[r_nfree_idx] <= r_seq;
                        r_nh[r_nfree_idx] <= r_seconds;
                        r_do_set          <= 1'b1;
                        r_cost            <= 10'd1;
                    end else begin
                        r_full <= 1'b1;
                    end
                end
                OP_LOOK_CHK: begin
                    if (o_status.look_hit) begin
                        r_found <= 1'b1;
                        r_d     <= r_k;
                        r_dcnt  <= dest_rd_cnt;
                        r_j     <= '0;
                    end else begin
                        if ((dest_rd_cnt == '0) && !r_dfree) begin
                            r_dfree     <= 1'b1;
                            r_dfree_idx <= r_k;
                        end
                        r_k <= r_k + DW'(1);
                    end
                end
                OP_VIA_CHK: begin
                    r_min_all <= min_dist(r_min_all, via_rd_dist);
                    if ((via_rd_addr == r_sender) && !r_match) begin
                        r_match <= 1'b1;
                        r_mj    <= r_j[NW-1:0];
                    end else begin
                        r_min_oth <= min_dist(r_min_oth, via_rd_dist);
                    end
                    r_j <= r_j + NCW'(1);
                end
                OP_APPLY: begin
                    if (r_do_set) begin
                        r_best    <= new_best;
                        r_changed <= (new_best != old_best);
                        if (apply_full) r_full <= 1'b1;
                    end else begin
                        r_best <= old_best;
                    end
                end
                OP_DONE: begin
                    r_ov      <= 1'b1;
                    r_ochg    <= r_changed;
                    r_obest   <= r_best;
                    r_opend   <= r_pending || r_changed;
                    r_pending <= r_pending || r_changed;
                    r_ofull   <= r_full;
                    r_olost   <= r_lost;
                end
                OP_TICK_CHK: begin
                    r_k <= '0;
                    if (o_status.tick_drop) begin
                        r_nv[r_ni]  <= 1'b0;
                        r_pending   <= 1'b1;
                        r_drop_addr <= r_na[r_ni];
                        if (r_lost != 4'd15) r_lost <= r_lost + 4'd1;
                    end else begin
                        r_ni <= r_ni + NW'(1);
                    end
                end
                OP_DROP_CHK: begin
                    if (dest_rd_cnt == '0) begin
                        r_k <= r_k + DW'(1);
                    end else begin
                        r_dcnt     <= dest_rd_cnt;
                        r_daddr    <= dest_rd_addr;
                        r_j        <= '0;
                        r_w        <= '0;
                        r_dmin_old <= UNREACHABLE;
                        r_dmin_new <= UNREACHABLE;
                    end
                end
                OP_DV_CHK: begin
                    r_dmin_old <= min_dist(r_dmin_old, via_rd_dist);
                    if (via_keep) begin
                        r_w        <= r_w + NCW'(1);
                        r_dmin_new <= min_dist(r_dmin_new, via_rd_dist);
                    end
                    r_j <= r_j + NCW'(1);
                end
                OP_DV_END: begin
                    if (r_dmin_new != r_dmin_old) r_changed <= 1'b1;
                    r_k <= r_k + DW'(1);
                end
                OP_NONE, OP_LOOK_RD, OP_VIA_RD, OP_DROP_RD, OP_DV_RD: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result.valid          = r_ov;
    assign o_result.best_changed   = r_ochg;
    assign o_result.best_distance  = r_obest;
    assign o_result.update_pending = r_opend;
    assign o_result.table_full     = r_ofull;
    assign o_result.neighbors_lost = r_olost;

`ifndef SYNTHESIS
    // a changed best cost always leaves an update pending
    a_chg_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_DONE) |=> (!r_ochg || r_opend))
        else $error("best change reported without pending update");

    // purged neighbours only ever come from a tick
    a_lost_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_op == OP_DONE) && (r_lost != 4'd0)) |-> (r_kind == KIND_TICK && r_pending))
        else $error("neighbours lost outside a tick");

    // via scans never run past the per-destination entry limit
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_op == OP_VIA_RD) || (i_op == OP_DV_RD)) |-> (r_dcnt <= NCW'(NEIGHBOR_SLOTS)))
        else $error("entry count above neighbour slots");
`endif

endmodule

`default_nettype wire

### sv/distance_vector_route_table_top.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_top
// distance-vector routing table with neighbour aging and apb configuration
// ----------------------------------------------------------------------------
//
// channel    dir   handshake         word
// i_item     in    valid / ready     kind, sender, destination, sequence, distance
// o_result   out   valid / ready     changed, best, pending, full, lost
// apb        in    psel / penable    own_address (0x0), neighbor_timeout_secs (0x4)
//
// processing: one word at a time; a lookup walks the destination memory, up to
//   every slot, with a read and a check per slot, then per via entry of the hit
// a tick additionally sweeps every destination and its via entries once per
//   purged neighbour, so its length grows with neighbours lost
// reset: synchronous; afterwards the destination memory is cleared slot by slot
//   while i_item.ready stays low (apb writes are taken as ever)
// stalls: the result register frees the input side; a new word is taken while
//   a result waits, and only the final write of the next result waits on it
//
`default_nettype none

module distance_vector_route_table_top
    import dvrt_pkg::*;
#(
    parameter int NEIGHBOR_SLOTS = 8,
    parameter int DEST_SLOTS     = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    dvrt_in_if.sink          i_item,
    dvrt_out_if.source       o_result,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [31:0] r_own_address;
    logic [15:0] r_timeout_secs;
    logic        cfg_write;

    t_dp_op     dp_op;
    t_dp_status dp_status;

    // register writes complete in the access phase, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address  <= '0;
            r_timeout_secs <= TIMEOUT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_OWN_ADDRESS) r_own_address  <= pwdata;
            else                             r_timeout_secs <= pwdata[15:0];
        end
    end

    // read back, the timeout zero-extended
    assign prdata = (paddr[2] == REG_NEIGHBOR_TIMEOUT) ? {16'd0, r_timeout_secs}
                                                       : r_own_address;

    // sequencer
    dvrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_status(dp_status),
        .o_op    (dp_op)
    );

    // tables, memories and result register
    dvrt_dp #(
        .NEIGHBOR_SLOTS(NEIGHBOR_SLOTS),
        .DEST_SLOTS    (DEST_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (dp_op),
        .o_status      (dp_status),
        .i_own_address (r_own_address),
        .i_timeout_secs(r_timeout_secs),
        .i_item        (i_item),
        .o_result      (o_result)
    );

endmodule

`default_nettype wire
